### rtl/pss_pkg.sv
package pss_pkg;

    localparam int unsigned LevelWidth = 16;
    localparam int unsigned TimerWidth = 16;
    localparam int unsigned RetryWidth = 8;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 16;

    localparam logic [TimerWidth-1:0] TimerMax = '1;

    typedef enum logic [1:0] {
        FUNC_CHECK  = 2'd0,
        FUNC_ON     = 2'd1,
        FUNC_OFF    = 2'd2,
        FUNC_MOTION = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OFF      = 3'd0,
        ST_TURN_OFF = 3'd1,
        ST_TURN_ON  = 3'd2,
        ST_ON       = 3'd3,
        ST_OFF_FAIL = 3'd4,
        ST_ON_FAIL  = 3'd5
    } status_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_OFF_THRESHOLD     = 3'd0,
        REG_ON_REFERENCE      = 3'd1,
        REG_ON_MARGIN         = 3'd2,
        REG_OFF_TIMEOUT_TICKS = 3'd3,
        REG_ON_TIMEOUT_TICKS  = 3'd4,
        REG_MAX_RETRIES       = 3'd5,
        REG_MOTION_HOLD_TICKS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [LevelWidth-1:0] off_threshold;
        logic [LevelWidth-1:0] on_reference;
        logic [LevelWidth-1:0] on_margin;
        logic [TimerWidth-1:0] off_timeout_ticks;
        logic [TimerWidth-1:0] on_timeout_ticks;
        logic [RetryWidth-1:0] max_retries;
        logic [TimerWidth-1:0] motion_hold_ticks;
    } cfg_t;

    typedef struct packed {
        func_t                 func;
        logic [LevelWidth-1:0] acc_level;
        logic                  guard_blocked;
        logic                  wheel_moving;
        logic                  auto_guard;
        logic                  link_up;
    } item_t;

    typedef struct packed {
        logic    switch_on;
        status_t status;
        logic    notify;
    } result_t;

endpackage

### rtl/pss_cfg.sv
module pss_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 wr_en,
    input  logic [pss_pkg::CfgIndexWidth-1:0]    wr_index,
    input  logic [pss_pkg::CfgDataWidth-1:0]     wr_data,
    output pss_pkg::cfg_t                        cfg
);

    pss_pkg::cfg_t cfg_reg;
    pss_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                pss_pkg::REG_OFF_THRESHOLD:     cfg_next.off_threshold = wr_data;
                pss_pkg::REG_ON_REFERENCE:      cfg_next.on_reference = wr_data;
                pss_pkg::REG_ON_MARGIN:         cfg_next.on_margin = wr_data;
                pss_pkg::REG_OFF_TIMEOUT_TICKS: cfg_next.off_timeout_ticks = wr_data;
                pss_pkg::REG_ON_TIMEOUT_TICKS:  cfg_next.on_timeout_ticks = wr_data;
                pss_pkg::REG_MAX_RETRIES:
                    cfg_next.max_retries = wr_data[pss_pkg::RetryWidth-1:0];
                pss_pkg::REG_MOTION_HOLD_TICKS: cfg_next.motion_hold_ticks = wr_data;
                default: ;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pss_core.sv
module pss_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  pss_pkg::item_t    item,
    input  pss_pkg::cfg_t     cfg,
    output pss_pkg::result_t  result
);

    pss_pkg::status_t                    status_reg, status_next;
    logic                                switch_reg, switch_next;
    logic [pss_pkg::TimerWidth-1:0]      timer_reg, timer_next;
    logic [pss_pkg::RetryWidth-1:0]      retry_reg, retry_next;
    logic                                pend_reg, pend_next;
    logic                                latch_reg, latch_next;
    logic [pss_pkg::TimerWidth-1:0]      hold_reg, hold_next;

    logic [pss_pkg::LevelWidth-1:0]      on_floor;
    logic                                level_on;
    logic                                level_off;
    logic [pss_pkg::TimerWidth-1:0]      timer_inc;
    logic [pss_pkg::TimerWidth-1:0]      hold_dec;
    logic                                note;

    // on floor is reference minus margin, clamped at zero
    assign on_floor  = (cfg.on_reference > cfg.on_margin) ?
                       (cfg.on_reference - cfg.on_margin) : '0;
    assign level_on  = item.acc_level > on_floor;
    assign level_off = item.acc_level < cfg.off_threshold;
    assign timer_inc = (timer_reg != pss_pkg::TimerMax) ?
                       (timer_reg + 1'b1) : timer_reg;
    assign hold_dec  = (hold_reg != '0) ? (hold_reg - 1'b1) : hold_reg;

    always_comb begin
        status_next = status_reg;
        switch_next = switch_reg;
        timer_next  = timer_reg;
        retry_next  = retry_reg;
        pend_next   = pend_reg;
        latch_next  = latch_reg;
        hold_next   = hold_reg;
        note        = 1'b0;

        case (item.func)
            pss_pkg::FUNC_CHECK: begin
                timer_next = timer_inc;
                if (status_reg == pss_pkg::ST_TURN_OFF) begin
                    if (level_off) begin
                        status_next = pss_pkg::ST_OFF;
                        pend_next   = 1'b1;
                    end else if (timer_inc >= cfg.off_timeout_ticks) begin
                        if (retry_reg < cfg.max_retries) begin
                            retry_next  = retry_reg + 1'b1;
                            switch_next = 1'b0;
                            timer_next  = '0;
                        end else begin
                            status_next = pss_pkg::ST_OFF_FAIL;
                            pend_next   = 1'b1;
                        end
                    end
                end else if (status_reg == pss_pkg::ST_TURN_ON) begin
                    if (level_on) begin
                        status_next = pss_pkg::ST_ON;
                        pend_next   = 1'b1;
                    end else if (timer_inc >= cfg.on_timeout_ticks) begin
                        if (retry_reg < cfg.max_retries) begin
                            retry_next  = retry_reg + 1'b1;
                            switch_next = 1'b1;
                            timer_next  = '0;
                        end else begin
                            status_next = pss_pkg::ST_ON_FAIL;
                            pend_next   = 1'b1;
                        end
                    end
                end
                // pending notice goes out now, dropped if the link is down
                if (pend_next) begin
                    note      = item.link_up;
                    pend_next = 1'b0;
                end
            end
            pss_pkg::FUNC_ON: begin
                if (!item.guard_blocked) begin
                    if (level_on) begin
                        status_next = pss_pkg::ST_ON;
                        pend_next   = 1'b1;
                    end else begin
                        status_next = pss_pkg::ST_TURN_ON;
                        switch_next = 1'b1;
                        timer_next  = '0;
                    end
                    retry_next = '0;
                end
            end
            pss_pkg::FUNC_OFF: begin
                status_next = pss_pkg::ST_TURN_OFF;
                switch_next = 1'b0;
                timer_next  = '0;
                retry_next  = '0;
            end
            pss_pkg::FUNC_MOTION: begin
                hold_next = hold_dec;
                if (status_reg == pss_pkg::ST_OFF && item.auto_guard) begin
                    if (!item.wheel_moving) begin
                        if (latch_reg && hold_dec == '0) begin
                            latch_next  = 1'b0;
                            switch_next = 1'b0;
                            timer_next  = '0;
                        end
                    end else begin
                        if (!latch_reg) begin
                            latch_next  = 1'b1;
                            switch_next = 1'b1;
                            timer_next  = '0;
                        end
                        hold_next = cfg.motion_hold_ticks;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= pss_pkg::ST_OFF;
            switch_reg <= 1'b0;
            timer_reg  <= '0;
            retry_reg  <= '0;
            pend_reg   <= 1'b0;
            latch_reg  <= 1'b0;
            hold_reg   <= '0;
        end else if (step) begin
            status_reg <= status_next;
            switch_reg <= switch_next;
            timer_reg  <= timer_next;
            retry_reg  <= retry_next;
            pend_reg   <= pend_next;
            latch_reg  <= latch_next;
            hold_reg   <= hold_next;
        end
    end

    assign result.switch_on = switch_next;
    assign result.status    = status_next;
    assign result.notify    = note;

endmodule

### rtl/power_switch_sequencer_with_retry_unit.sv
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// input    | s_valid / s_ready     | s_func, s_acc_level, s_guard_blocked,
//          |                       | s_wheel_moving, s_auto_guard, s_link_up
// result   | m_valid / m_ready     | m_switch_on, m_status, m_notify
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while the result side keeps m_ready high; an item
// lands in the input register, then its result is computed and captured in the
// result register once that register is free, which raises m_valid
// aresetn is synchronous, active low, and clears the sequencer state, config
// registers and both valid flags
// a stalled result holds the input register; the input register still refills
// in the same cycle the result register drains
module power_switch_sequencer_with_retry_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [pss_pkg::LevelWidth-1:0]      s_acc_level,
    input  logic                                s_guard_blocked,
    input  logic                                s_wheel_moving,
    input  logic                                s_auto_guard,
    input  logic                                s_link_up,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_switch_on,
    output logic [2:0]                          m_status,
    output logic                                m_notify,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pss_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [pss_pkg::CfgDataWidth-1:0]    cfg_data
);

    pss_pkg::cfg_t    cfg;
    pss_pkg::item_t   item_reg;
    logic             item_valid_reg;
    pss_pkg::result_t core_result;
    pss_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             advance;
    logic             s_accept;

    // write config only while idle (not enforced); writes are always taken
    assign cfg_ready = 1'b1;

    pss_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register moves into the result register when that one is free
    assign advance  = item_valid_reg & (~result_valid_reg | m_ready);
    assign s_ready  = ~item_valid_reg | advance;
    assign s_accept = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func          <= pss_pkg::func_t'(s_func);
            item_reg.acc_level     <= s_acc_level;
            item_reg.guard_blocked <= s_guard_blocked;
            item_reg.wheel_moving  <= s_wheel_moving;
            item_reg.auto_guard    <= s_auto_guard;
            item_reg.link_up       <= s_link_up;
        end
    end

    // sequencer state commits on the same edge the result is captured
    pss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= core_result;
        end
    end

    assign m_valid     = result_valid_reg;
    assign m_switch_on = result_reg.switch_on;
    assign m_status    = result_reg.status;
    assign m_notify    = result_reg.notify;

endmodule

### test/power_switch_sequencer_with_retry_unit_tb.sv
module power_switch_sequencer_with_retry_unit_tb;

    // state mirror of the sequencer: predicts one result per accepted item
    class psu_scoreboard;
        pss_pkg::cfg_t                  cfg;
        pss_pkg::status_t               pstat;
        logic                           sw_level;
        logic [pss_pkg::TimerWidth-1:0] act_timer;
        logic [pss_pkg::RetryWidth-1:0] retries;
        logic                           notify_due;
        logic                           motion_latch;
        logic [pss_pkg::TimerWidth-1:0] hold_timer;
        pss_pkg::result_t               awaited[$];
        int unsigned                    err_count;

        function new();
            cfg = '0;
            pstat = pss_pkg::ST_OFF;
            sw_level = 1'b0;
            act_timer = '0;
            retries = '0;
            notify_due = 1'b0;
            motion_latch = 1'b0;
            hold_timer = '0;
            err_count = 0;
        endfunction

        function void write_reg(logic [pss_pkg::CfgIndexWidth-1:0] idx,
                                logic [pss_pkg::CfgDataWidth-1:0] val);
            case (idx)
                pss_pkg::REG_OFF_THRESHOLD:     cfg.off_threshold = val;
                pss_pkg::REG_ON_REFERENCE:      cfg.on_reference = val;
                pss_pkg::REG_ON_MARGIN:         cfg.on_margin = val;
                pss_pkg::REG_OFF_TIMEOUT_TICKS: cfg.off_timeout_ticks = val;
                pss_pkg::REG_ON_TIMEOUT_TICKS:  cfg.on_timeout_ticks = val;
                pss_pkg::REG_MAX_RETRIES:
                    cfg.max_retries = val[pss_pkg::RetryWidth-1:0];
                pss_pkg::REG_MOTION_HOLD_TICKS: cfg.motion_hold_ticks = val;
                default: ;
            endcase
        endfunction

        // reference minus margin, floored at zero
        function logic [pss_pkg::LevelWidth-1:0] on_floor();
            if (cfg.on_reference > cfg.on_margin)
                return cfg.on_reference - cfg.on_margin;
            return '0;
        endfunction

        function logic level_on(logic [pss_pkg::LevelWidth-1:0] lvl);
            return lvl > on_floor();
        endfunction

        function void redrive(logic level);
            sw_level = level;
            act_timer = '0;
        endfunction

        function void timeout_step(logic [pss_pkg::TimerWidth-1:0] limit, logic level,
                                   pss_pkg::status_t fail_code);
            if (act_timer >= limit) begin
                if (retries < cfg.max_retries) begin
                    retries = retries + 1'b1;
                    redrive(level);
                end else begin
                    pstat = fail_code;
                    notify_due = 1'b1;
                end
            end
        endfunction

        function void note_item(pss_pkg::item_t it);
            pss_pkg::result_t r;
            logic             note;
            note = 1'b0;
            case (it.func)
                pss_pkg::FUNC_CHECK: begin
                    if (act_timer != pss_pkg::TimerMax)
                        act_timer = act_timer + 1'b1;
                    if (pstat == pss_pkg::ST_TURN_OFF) begin
                        if (it.acc_level < cfg.off_threshold) begin
                            pstat = pss_pkg::ST_OFF;
                            notify_due = 1'b1;
                        end else begin
                            timeout_step(cfg.off_timeout_ticks, 1'b0,
                                         pss_pkg::ST_OFF_FAIL);
                        end
                    end else if (pstat == pss_pkg::ST_TURN_ON) begin
                        if (level_on(it.acc_level)) begin
                            pstat = pss_pkg::ST_ON;
                            notify_due = 1'b1;
                        end else begin
                            timeout_step(cfg.on_timeout_ticks, 1'b1,
                                         pss_pkg::ST_ON_FAIL);
                        end
                    end
                    if (notify_due) begin
                        note = it.link_up;
                        notify_due = 1'b0;
                    end
                end
                pss_pkg::FUNC_ON: begin
                    if (!it.guard_blocked) begin
                        if (level_on(it.acc_level)) begin
                            pstat = pss_pkg::ST_ON;
                            notify_due = 1'b1;
                        end else begin
                            pstat = pss_pkg::ST_TURN_ON;
                            redrive(1'b1);
                        end
                        retries = '0;
                    end
                end
                pss_pkg::FUNC_OFF: begin
                    pstat = pss_pkg::ST_TURN_OFF;
                    redrive(1'b0);
                    retries = '0;
                end
                default: begin
                    if (hold_timer != '0)
                        hold_timer = hold_timer - 1'b1;
                    if (pstat == pss_pkg::ST_OFF && it.auto_guard) begin
                        if (!it.wheel_moving) begin
                            if (motion_latch && hold_timer == '0) begin
                                motion_latch = 1'b0;
                                redrive(1'b0);
                            end
                        end else begin
                            if (!motion_latch) begin
                                motion_latch = 1'b1;
                                redrive(1'b1);
                            end
                            hold_timer = cfg.motion_hold_ticks;
                        end
                    end
                end
            endcase
            r.switch_on = sw_level;
            r.status = pstat;
            r.notify = note;
            awaited.push_back(r);
        endfunction

        function void check_result(logic sw, logic [2:0] st, logic nt);
            pss_pkg::result_t exp;
            if (awaited.size() == 0) begin
                $display("%0t unexpected result: switch_on %0d status %0d notify %0d",
                         $time, sw, st, nt);
                err_count++;
                return;
            end
            exp = awaited.pop_front();
            if (exp.switch_on !== sw) begin
                $display("%0t switch_on mismatch: expected %0d actual %0d",
                         $time, exp.switch_on, sw);
                err_count++;
            end
            if (exp.status !== st) begin
                $display("%0t status mismatch: expected %0d actual %0d",
                         $time, exp.status, st);
                err_count++;
            end
            if (exp.notify !== nt) begin
                $display("%0t notify mismatch: expected %0d actual %0d",
                         $time, exp.notify, nt);
                err_count++;
            end
        endfunction
    endclass

    // index past the last register, must be ignored by the block
    localparam logic [pss_pkg::CfgIndexWidth-1:0] RegUnused = 3'd7;
    localparam int unsigned PhaseCount = 12;
    localparam int unsigned PhaseItems = 150;
    localparam int unsigned LongHoldCycles = 400;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [1:0]                        s_func;
    logic [pss_pkg::LevelWidth-1:0]    s_acc_level;
    logic                              s_guard_blocked;
    logic                              s_wheel_moving;
    logic                              s_auto_guard;
    logic                              s_link_up;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_switch_on;
    logic [2:0]                        m_status;
    logic                              m_notify;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [pss_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [pss_pkg::CfgDataWidth-1:0]  cfg_data;

    psu_scoreboard sb;
    int unsigned   sent_count = 0;
    // calm: no idling on either side; long_hold_req: receiver backs off for a long stretch
    bit            calm = 1'b0;
    bit            long_hold_req = 1'b0;

    power_switch_sequencer_with_retry_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_acc_level     (s_acc_level),
        .s_guard_blocked (s_guard_blocked),
        .s_wheel_moving  (s_wheel_moving),
        .s_auto_guard    (s_auto_guard),
        .s_link_up       (s_link_up),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_switch_on     (m_switch_on),
        .m_status        (m_status),
        .m_notify        (m_notify),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // wide values: levels, reference and margin
    function automatic logic [15:0] pick_wide();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        if (r < 6)
            return 16'($urandom_range(0, 2000));
        return 16'($urandom_range(0, 65535));
    endfunction

    // tick counts: kept small so timeouts and retries show up often
    function automatic logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom_range(1, 6));
    endfunction

    // levels close to the on and off decision points
    function automatic logic [15:0] pick_level();
        logic [15:0] fl;
        logic [15:0] th;
        fl = sb.on_floor();
        th = sb.cfg.off_threshold;
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return fl;
            3: return (fl == 16'hffff) ? fl : fl + 1'b1;
            4: return th;
            5: return (th == 16'h0000) ? th : th - 1'b1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pss_pkg::item_t mk(pss_pkg::func_t f, logic [15:0] lvl, logic blk,
                                          logic mv, logic ag, logic lk);
        pss_pkg::item_t it;
        it.func = f;
        it.acc_level = lvl;
        it.guard_blocked = blk;
        it.wheel_moving = mv;
        it.auto_guard = ag;
        it.link_up = lk;
        return it;
    endfunction

    // random flags: guard rarely blocks, link mostly up
    function automatic pss_pkg::item_t rand_item(pss_pkg::func_t f, logic [15:0] lvl);
        return mk(f, lvl, $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
    endfunction

    task automatic send_item(input pss_pkg::item_t it);
        int gap;
        s_valid <= 1'b1;
        s_func <= it.func;
        s_acc_level <= it.acc_level;
        s_guard_blocked <= it.guard_blocked;
        s_wheel_moving <= it.wheel_moving;
        s_auto_guard <= it.auto_guard;
        s_link_up <= it.link_up;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        sent_count++;
        gap = pick_gap();
        // valid stays up on a zero gap, so the next item follows back to back
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [pss_pkg::CfgIndexWidth-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every expected item came back, then wait out the pipeline slack
    task automatic settle();
        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // result side: check on each handshake, then pick the next ready level
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_switch_on, m_status, m_notify);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LongHoldCycles;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end
        end
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int             kind;
        int             n;
        int unsigned    start;
        logic           mv;
        logic [15:0]    th;
        logic [15:0]    fl;
        pss_pkg::item_t it;

        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = pss_pkg::FUNC_CHECK;
        s_acc_level = '0;
        s_guard_blocked = 1'b0;
        s_wheel_moving = 1'b0;
        s_auto_guard = 1'b0;
        s_link_up = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed setup: on floor 900, off below 100, short timeouts, one retry
        write_reg(pss_pkg::REG_OFF_THRESHOLD, 16'd100);
        write_reg(pss_pkg::REG_ON_REFERENCE, 16'd1000);
        write_reg(pss_pkg::REG_ON_MARGIN, 16'd100);
        write_reg(pss_pkg::REG_OFF_TIMEOUT_TICKS, 16'd2);
        write_reg(pss_pkg::REG_ON_TIMEOUT_TICKS, 16'd3);
        write_reg(pss_pkg::REG_MAX_RETRIES, 16'd1);
        write_reg(pss_pkg::REG_MOTION_HOLD_TICKS, 16'd2);
        write_reg(RegUnused, 16'hffff);

        // tick while off, then a blocked on-command
        send_item(mk(pss_pkg::FUNC_CHECK, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(mk(pss_pkg::FUNC_ON, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
        // level already above the floor: straight to on, notified on next tick
        send_item(mk(pss_pkg::FUNC_ON, 16'd901, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(mk(pss_pkg::FUNC_CHECK, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        // off confirmed with the link down: pending flag drops silently
        send_item(mk(pss_pkg::FUNC_OFF, 16'd500, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(mk(pss_pkg::FUNC_CHECK, 16'd99, 1'b0, 1'b0, 1'b0, 1'b0));
        // level equal to the floor is not on: turn on, one retry, then on failed
        send_item(mk(pss_pkg::FUNC_ON, 16'd900, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (3) send_item(mk(pss_pkg::FUNC_CHECK, 16'd900, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (3) send_item(mk(pss_pkg::FUNC_CHECK, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        // level at the threshold never counts as off: retry, then off failed
        send_item(mk(pss_pkg::FUNC_OFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (4) send_item(mk(pss_pkg::FUNC_CHECK, 16'd100, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(mk(pss_pkg::FUNC_OFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(mk(pss_pkg::FUNC_CHECK, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        // motion wake in auto mode, hold runs out, then motion without auto
        send_item(mk(pss_pkg::FUNC_MOTION, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item(mk(pss_pkg::FUNC_MOTION, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(mk(pss_pkg::FUNC_MOTION, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(mk(pss_pkg::FUNC_MOTION, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        // turn on confirmed at full scale
        send_item(mk(pss_pkg::FUNC_ON, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(mk(pss_pkg::FUNC_CHECK, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b1));
        s_valid <= 1'b0;

        for (int p = 0; p < PhaseCount; p++) begin
            settle();
            // new settings only while the pipeline is empty
            if (p == 1) begin
                write_reg(pss_pkg::REG_OFF_THRESHOLD, 16'h0000);
                write_reg(pss_pkg::REG_ON_REFERENCE, 16'h0000);
                write_reg(pss_pkg::REG_ON_MARGIN, 16'h0000);
                write_reg(pss_pkg::REG_OFF_TIMEOUT_TICKS, 16'h0000);
                write_reg(pss_pkg::REG_ON_TIMEOUT_TICKS, 16'h0000);
                write_reg(pss_pkg::REG_MAX_RETRIES, 16'h0000);
                write_reg(pss_pkg::REG_MOTION_HOLD_TICKS, 16'h0000);
            end else if (p == 2) begin
                write_reg(pss_pkg::REG_OFF_THRESHOLD, 16'hffff);
                write_reg(pss_pkg::REG_ON_REFERENCE, 16'hffff);
                write_reg(pss_pkg::REG_ON_MARGIN, 16'hffff);
                write_reg(pss_pkg::REG_OFF_TIMEOUT_TICKS, 16'hffff);
                write_reg(pss_pkg::REG_ON_TIMEOUT_TICKS, 16'hffff);
                write_reg(pss_pkg::REG_MAX_RETRIES, 16'hffff);
                write_reg(pss_pkg::REG_MOTION_HOLD_TICKS, 16'hffff);
            end else begin
                write_reg(pss_pkg::REG_OFF_THRESHOLD, pick_wide());
                write_reg(pss_pkg::REG_ON_REFERENCE, pick_wide());
                write_reg(pss_pkg::REG_ON_MARGIN, pick_wide());
                write_reg(pss_pkg::REG_OFF_TIMEOUT_TICKS, pick_ticks());
                write_reg(pss_pkg::REG_ON_TIMEOUT_TICKS, pick_ticks());
                n = $urandom_range(0, 9);
                write_reg(pss_pkg::REG_MAX_RETRIES, (n == 0) ? 16'd255 :
                          (n == 1) ? 16'd0 : 16'($urandom_range(0, 3)));
                write_reg(pss_pkg::REG_MOTION_HOLD_TICKS, pick_ticks());
                if ($urandom_range(0, 3) == 0)
                    write_reg(RegUnused, 16'($urandom));
            end
            calm = (p == 5);
            if (p == 3)
                long_hold_req = 1'b1;

            start = sent_count;
            while (sent_count - start < PhaseItems) begin
                th = sb.cfg.off_threshold;
                fl = sb.on_floor();
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    // power-on episode: levels mostly at or below the floor
                    send_item(rand_item(pss_pkg::FUNC_ON, ($urandom_range(0, 3) == 0) ?
                                        pick_level() : 16'($urandom_range(0, fl))));
                    n = $urandom_range(1, 10);
                    repeat (n) send_item(rand_item(pss_pkg::FUNC_CHECK,
                                                   ($urandom_range(0, 4) == 0) ?
                                                   pick_level() :
                                                   16'($urandom_range(0, fl))));
                end else if (kind < 6) begin
                    // power-off episode: levels mostly at or above the threshold
                    send_item(rand_item(pss_pkg::FUNC_OFF, 16'($urandom)));
                    n = $urandom_range(1, 10);
                    repeat (n) send_item(rand_item(pss_pkg::FUNC_CHECK,
                                                   ($urandom_range(0, 4) == 0) ?
                                                   pick_level() :
                                                   16'($urandom_range(th, 16'hffff))));
                end else if (kind < 8) begin
                    // get to off, then a run of motion ticks in auto mode
                    send_item(rand_item(pss_pkg::FUNC_OFF, 16'($urandom)));
                    send_item(rand_item(pss_pkg::FUNC_CHECK, (th == 16'h0000) ? 16'h0000 :
                                        16'($urandom_range(0, th - 1'b1))));
                    n = $urandom_range(1, 12);
                    mv = 1'($urandom_range(0, 1));
                    repeat (n) begin
                        if ($urandom_range(0, 2) == 0)
                            mv = ~mv;
                        it = rand_item(pss_pkg::FUNC_MOTION, 16'($urandom));
                        it.wheel_moving = mv;
                        it.auto_guard = $urandom_range(0, 5) != 0;
                        send_item(it);
                    end
                end else begin
                    // noise: anything goes
                    n = $urandom_range(1, 5);
                    repeat (n) begin
                        it = mk(pss_pkg::func_t'(2'($urandom_range(0, 3))), 16'($urandom),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        send_item(it);
                    end
                end
            end
            s_valid <= 1'b0;
            calm = 1'b0;
        end

        settle();
        repeat (10) @(posedge aclk);
        if (sb.err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
